@@ src/cfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared constants and types of the compass frame parser.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PosW   = 4;
  localparam int unsigned FieldW = 16;

  localparam logic [ByteW-1:0] SyncFirst  = 8'hB5;
  localparam logic [ByteW-1:0] SyncSecond = 8'h62;

  localparam logic [PosW-1:0] PosHunt      = 4'd0;
  localparam logic [PosW-1:0] PosSync      = 4'd1;
  localparam logic [PosW-1:0] PosBodyFirst = 4'd2;
  localparam logic [PosW-1:0] PosDataFirst = 4'd6;
  localparam logic [PosW-1:0] PosDataLast  = 4'd11;
  localparam logic [PosW-1:0] PosChkA      = 4'd12;
  localparam logic [PosW-1:0] PosChkB      = 4'd13;

  localparam int unsigned DataW = 6 * ByteW;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [PosW-1:0]  pos;
  } body_item_t;

endpackage

@@ src/cfp_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_front
// Sync hunt and byte position tracking; forwards frame body bytes.
// ----------------------------------------------------------------------------
module cfp_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [cfp_pkg::ByteW-1:0] rx_byte_i,
  output logic                     push_valid_o,
  output cfp_pkg::body_item_t      push_item_o,
  input  logic                     queue_full_i
);
  import cfp_pkg::*;

  logic [PosW-1:0] count_q, count_d;
  logic            in_body;
  logic            accept;

  assign in_body      = (count_q >= PosBodyFirst) && (count_q <= PosChkB);
  assign in_ready_o   = !in_body || !queue_full_i;
  assign accept       = in_valid_i && in_ready_o;
  assign push_valid_o = accept && in_body;
  assign push_item_o  = '{data: rx_byte_i, pos: count_q};

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (count_q == PosHunt) begin
        if (rx_byte_i == SyncFirst) count_d = PosSync;
      end else if (count_q == PosSync) begin
        if (rx_byte_i == SyncSecond) count_d = PosBodyFirst;
        else if (rx_byte_i != SyncFirst) count_d = PosHunt;
      end else if (count_q >= PosChkB) begin
        count_d = PosHunt;
      end else begin
        count_d = count_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) count_q <= PosHunt;
    else count_q <= count_d;
  end

endmodule

@@ src/cfp_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_queue
// Two-entry queue of body bytes between front and back.
// ----------------------------------------------------------------------------
module cfp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  cfp_pkg::body_item_t push_item_i,
  output logic                full_o,
  output logic                pop_valid_o,
  output cfp_pkg::body_item_t pop_item_o,
  input  logic                pop_i
);
  import cfp_pkg::*;

  body_item_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_item_o  = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

@@ src/cfp_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_back
// Fletcher checksum, field capture and registered result output.
// ----------------------------------------------------------------------------
module cfp_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             pop_valid_i,
  input  cfp_pkg::body_item_t              pop_item_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [cfp_pkg::FieldW-1:0] field_x_o,
  output logic signed [cfp_pkg::FieldW-1:0] field_y_o,
  output logic signed [cfp_pkg::FieldW-1:0] field_z_o
);
  import cfp_pkg::*;

  logic [ByteW-1:0]  sum_a_q, sum_a_d, sum_b_q, sum_b_d, chk_a_q;
  logic [DataW-1:0]  data_q;
  logic              out_valid_q, out_valid_d;
  logic              is_last, match;
  logic [ByteW-1:0]  b;

  assign b       = pop_item_i.data;
  assign is_last = (pop_item_i.pos == PosChkB);
  assign pop_o   = pop_valid_i && (!is_last || !out_valid_q || out_ready_i);
  assign match   = (chk_a_q == sum_a_q) && (b == sum_b_q);

  always_comb begin
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (pop_o) begin
      if (pop_item_i.pos == PosBodyFirst) begin
        sum_a_d = b;
        sum_b_d = b;
      end else if (pop_item_i.pos <= PosDataLast) begin
        sum_a_d = sum_a_q + b;
        sum_b_d = sum_b_q + sum_a_d;
      end
    end
    out_valid_d = out_valid_q && !out_ready_i;
    if (pop_o && is_last && match) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    sum_a_q <= sum_a_d;
    sum_b_q <= sum_b_d;
    if (pop_o && pop_item_i.pos >= PosDataFirst && pop_item_i.pos <= PosDataLast) begin
      data_q <= {data_q[DataW-ByteW-1:0], b};
    end
    if (pop_o && pop_item_i.pos == PosChkA) chk_a_q <= b;
    if (pop_o && is_last && match) begin
      field_x_o <= data_q[DataW-1 -: FieldW];
      field_y_o <= data_q[DataW-FieldW-1 -: FieldW];
      field_z_o <= data_q[FieldW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else out_valid_q <= out_valid_d;
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/compass_frame_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_frame_parser_core
// Sync hunt, 14-byte frame collection, Fletcher check and field output.
// ----------------------------------------------------------------------------
// throughput: one byte per cycle; the front stalls only when the queue is full
// result: out_valid is registered when the back pops the last checksum byte from the queue and the checksum matches
// a waiting result stalls only the final byte of the next frame in the queue
// reset: asynchronous, active low; clears sync state, queue and output valid
module compass_frame_parser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [cfp_pkg::ByteW-1:0]         rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [cfp_pkg::FieldW-1:0] field_x_o,
  output logic signed [cfp_pkg::FieldW-1:0] field_y_o,
  output logic signed [cfp_pkg::FieldW-1:0] field_z_o
);
  import cfp_pkg::*;

  logic       push_valid, queue_full, pop_valid, pop;
  body_item_t push_item, pop_item;

  cfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .push_valid_o (push_valid),
    .push_item_o  (push_item),
    .queue_full_i (queue_full)
  );

  cfp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .push_item_i (push_item),
    .full_o      (queue_full),
    .pop_valid_o (pop_valid),
    .pop_item_o  (pop_item),
    .pop_i       (pop)
  );

  cfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .field_x_o   (field_x_o),
    .field_y_o   (field_y_o),
    .field_z_o   (field_z_o)
  );

endmodule

@@ src/cfp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_checker
// Port-level checks of the compass frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module cfp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [cfp_pkg::ByteW-1:0]         rx_byte_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [cfp_pkg::FieldW-1:0] field_x_o,
  input logic signed [cfp_pkg::FieldW-1:0] field_y_o,
  input logic signed [cfp_pkg::FieldW-1:0] field_z_o
);
  import cfp_pkg::*;

  // stalled input transaction holds its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(rx_byte_i))
    else $error("stalled input changed");

  // stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(field_x_o)
      && $stable(field_y_o) && $stable(field_z_o))
    else $error("stalled result changed");

  // a new result follows an accepted input transaction, checked with $past
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a closing input transaction");

  // no result right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind compass_frame_parser_core cfp_checker u_cfp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .rx_byte_i   (rx_byte_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .field_x_o   (field_x_o),
  .field_y_o   (field_y_o),
  .field_z_o   (field_z_o)
);
